/* src/ecrt_pkg.sv */
// ecrt_pkg: shared constants, controller states and command/status structs
// for the extended crt combiner; no dependencies
package ecrt_pkg;
   localparam int unsigned VALUE_WIDTH_DEF = 62;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MODM,     // m = m ? m : 1, start r mod m
      ST_RMOD,     // r mod m
      ST_AMOD,     // A mod m
      ST_C,        // c = (r + m - a) mod m
      ST_GCD,      // gcd operands: a = M, b = m
      ST_GCDW,
      ST_PG,       // pg = m / g
      ST_PGW,
      ST_CG,       // c mod g, c / g
      ST_CGW,
      ST_OVF,      // VMASK / pg
      ST_OVFW,
      ST_MG,       // M / g
      ST_MGW,
      ST_MGP,      // (M/g) mod pg
      ST_MGPW,
      ST_CGP,      // (c/g) mod pg
      ST_CGPW,
      ST_INV,      // euclid: r0 / r1
      ST_INVW,
      ST_INVM,     // q*t1 mod pg
      ST_INVMW,
      ST_INVT,     // t2 update
      ST_TMUL,     // t = inv * cg mod pg
      ST_TMULW,
      ST_PROD,     // M*t
      ST_PRODW,
      ST_LCMW,     // M*pg
      ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_FIXM, OP_DIV_RM, OP_DIV_AM, OP_SETC, OP_GCD_INIT,
      OP_DIV_GCD, OP_GCD_STEP, OP_DIV_PG, OP_SET_PG, OP_DIV_CG, OP_SET_CG,
      OP_DIV_OVF, OP_SET_OVF, OP_DIV_MG, OP_DIV_MGP, OP_SET_MGP, OP_DIV_CGP,
      OP_SET_CGP, OP_DIV_INV, OP_MUL_INV, OP_INV_STEP, OP_MUL_T, OP_MUL_PROD,
      OP_COMMIT, OP_SET_RM, OP_SET_AM, OP_SET_MG, OP_MUL_LCM, OP_CLOSE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic unit_busy;   // divider or multiplier running
      logic gcd_zero;    // b == 0
      logic r1_zero;
      logic fail_hit;    // c mod g != 0
      logic ovf_hit;     // M > VMASK / pg
      logic pg_gt1;
      logic skip;        // a flag already set (fail or overflow)
      logic at_start;
   } status_type;
endpackage

/* src/ecrt_datapath.sv */
// ecrt_datapath: operand registers, shared restoring divider and shared
// shift-and-add modular multiplier; depends on ecrt_pkg
module ecrt_datapath import ecrt_pkg::*; #(
   parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [VALUE_WIDTH-1:0] m_in_val,
   input  logic [VALUE_WIDTH-1:0] r_in_val,
   input  logic                   last_in_val,
   output status_type             status,
   output logic [VALUE_WIDTH-1:0] sol_out,
   output logic [VALUE_WIDTH-1:0] mod_out,
   output logic                   fail_out,
   output logic                   ovf_out,
   output logic                   last_out
);
   localparam int W = VALUE_WIDTH;
   localparam int CW = $clog2(W + 1);
   localparam logic [W-1:0] VMASK = {W{1'b1}};
   localparam logic [W-1:0] ONE = W'(1);

   // architectural state
   logic [W-1:0] sol_ff, sol_in, mod_ff, mod_in;
   logic         fail_ff, fail_in, ovf_ff, ovf_in, start_ff, start_in, last_ff, last_in;
   // working registers
   logic [W-1:0] m_ff, m_in, r_ff, r_in, c_ff, c_in, ga_ff, ga_in, gb_ff, gb_in;
   logic [W-1:0] pg_ff, pg_in, cg_ff, cg_in, mg_ff, mg_in;
   logic [W-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0] t_ff, t_in;
   logic         fhit_ff, fhit_in, ohit_ff, ohit_in;

   // divider: dq / dd -> quotient, remainder
   logic [W-1:0] dq_ff, dq_in, dd_ff, dd_in, rem_ff, rem_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic         dbusy_ff, dbusy_in;
   logic [W:0]   dtrial;

   // multiplier: (ma*mb) mod mn, or plain product (mplain set means plain)
   logic [W-1:0] ma_ff, ma_in, mb_ff, mb_in, mn_ff, mn_in, acc_ff, acc_in;
   logic         mbusy_ff, mbusy_in, mplain_ff, mplain_in;
   logic [W:0]   msum, mdbl;
   logic [W-1:0] msum_r, mdbl_r;

   always_comb begin
      dtrial = {rem_ff, dq_ff[W-1]} - {1'b0, dd_ff};
      msum = {1'b0, acc_ff} + {1'b0, ma_ff};
      mdbl = {ma_ff, 1'b0};
      msum_r = (!mplain_ff && msum >= {1'b0, mn_ff}) ? W'(msum - {1'b0, mn_ff}) : msum[W-1:0];
      mdbl_r = (!mplain_ff && mdbl >= {1'b0, mn_ff}) ? W'(mdbl - {1'b0, mn_ff}) : mdbl[W-1:0];
   end

   task automatic start_div(input logic [W-1:0] n, input logic [W-1:0] d);
      dq_in = n; dd_in = d; rem_in = '0; dcnt_in = CW'(W); dbusy_in = 1'b1;
   endtask

   task automatic start_mul(input logic [W-1:0] a, input logic [W-1:0] b,
                            input logic [W-1:0] n, input logic plain);
      ma_in = a; mb_in = b; mn_in = n; acc_in = '0; mbusy_in = 1'b1; mplain_in = plain;
   endtask

   always_comb begin
      logic [W-1:0] s;
      s = '0;
      sol_in = sol_ff; mod_in = mod_ff; fail_in = fail_ff; ovf_in = ovf_ff;
      start_in = start_ff; last_in = last_ff;
      m_in = m_ff; r_in = r_ff; c_in = c_ff; ga_in = ga_ff; gb_in = gb_ff;
      pg_in = pg_ff; cg_in = cg_ff; mg_in = mg_ff; r0_in = r0_ff; r1_in = r1_ff;
      t0_in = t0_ff; t1_in = t1_ff; t_in = t_ff; fhit_in = fhit_ff; ohit_in = ohit_ff;
      dq_in = dq_ff; dd_in = dd_ff; rem_in = rem_ff; dcnt_in = dcnt_ff; dbusy_in = dbusy_ff;
      ma_in = ma_ff; mb_in = mb_ff; mn_in = mn_ff; acc_in = acc_ff;
      mbusy_in = mbusy_ff; mplain_in = mplain_ff;

      // divider iteration
      if (dbusy_ff) begin
         if (!dtrial[W]) begin
            rem_in = dtrial[W-1:0]; dq_in = {dq_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], dq_ff[W-1]}; dq_in = {dq_ff[W-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - CW'(1);
         if (dcnt_ff == CW'(1)) dbusy_in = 1'b0;
      end
      // multiplier iteration
      if (mbusy_ff) begin
         if (mb_ff == '0) mbusy_in = 1'b0;
         else begin
            if (mb_ff[0]) acc_in = msum_r;
            ma_in = mdbl_r;
            mb_in = mb_ff >> 1;
         end
      end

      unique case (cmd.op)
         OP_LOAD: begin
            m_in = m_in_val; r_in = r_in_val; last_in = last_in_val;
         end
         OP_FIXM: begin
            if (m_ff == '0) m_in = ONE;
            start_div(r_ff, (m_ff == '0) ? ONE : m_ff);
         end
         OP_DIV_RM: start_div(sol_ff, m_ff);
         OP_SET_RM: begin
            r_in = rem_ff;
            if (start_ff) begin
               mod_in = m_ff; sol_in = rem_ff; fail_in = 1'b0; ovf_in = 1'b0;
               start_in = 1'b0;
            end
         end
         OP_DIV_AM: start_div(sol_ff, m_ff);
         OP_SET_AM: begin
            // c = (r + m - a) mod m, all below m
            s = r_ff - rem_ff;
            c_in = (r_ff >= rem_ff) ? s : W'(s + m_ff);
         end
         OP_SETC: begin
            ga_in = mod_ff; gb_in = m_ff;
         end
         OP_DIV_GCD: start_div(ga_ff, gb_ff);
         OP_GCD_STEP: begin
            ga_in = gb_ff; gb_in = rem_ff;
         end
         OP_DIV_PG: start_div(m_ff, ga_ff);
         OP_SET_PG: begin
            pg_in = dq_ff; start_div(c_ff, ga_ff);
         end
         OP_SET_CG: begin
            cg_in = dq_ff; fhit_in = (rem_ff != '0);
            start_div(VMASK, pg_ff);
         end
         OP_SET_OVF: begin
            ohit_in = (mod_ff > dq_ff);
            if (fhit_ff) fail_in = 1'b1;
            else if (mod_ff > dq_ff) ovf_in = 1'b1;
            start_div(mod_ff, ga_ff);
         end
         OP_SET_MG: begin
            mg_in = dq_ff; start_div(dq_ff, pg_ff);
         end
         OP_SET_MGP: begin
            mg_in = rem_ff; start_div(cg_ff, pg_ff);
         end
         OP_SET_CGP: begin
            cg_in = rem_ff;
            r0_in = pg_ff; r1_in = mg_ff; t0_in = '0; t1_in = ONE;
         end
         OP_DIV_INV: start_div(r0_ff, r1_ff);
         // a quotient equal to pg reduces to zero inside the multiplier
         OP_MUL_INV: start_mul(dq_ff, t1_ff, pg_ff, 1'b0);
         OP_INV_STEP: begin
            s = t0_ff - acc_ff;
            t1_in = (t0_ff >= acc_ff) ? s : W'(s + pg_ff);
            t0_in = t1_ff; r0_in = r1_ff; r1_in = rem_ff;
         end
         OP_MUL_T: start_mul(t0_ff, cg_ff, pg_ff, 1'b0);
         OP_MUL_PROD: begin
            t_in = status.pg_gt1 ? acc_ff : '0;
            start_mul(mod_ff, status.pg_gt1 ? acc_ff : '0, '0, 1'b1);
         end
         OP_MUL_LCM: begin
            // new solution held in t while the multiplier forms M*pg
            t_in = sol_ff + acc_ff;
            start_mul(mod_ff, pg_ff, '0, 1'b1);
         end
         OP_COMMIT: begin
            sol_in = t_ff;
            mod_in = acc_ff;
         end
         OP_CLOSE: if (last_ff) start_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sol_ff <= '0; mod_ff <= ONE; fail_ff <= 1'b0; ovf_ff <= 1'b0; start_ff <= 1'b1;
         dbusy_ff <= 1'b0; mbusy_ff <= 1'b0;
      end else begin
         sol_ff <= sol_in; mod_ff <= mod_in; fail_ff <= fail_in; ovf_ff <= ovf_in;
         start_ff <= start_in;
         dbusy_ff <= dbusy_in; mbusy_ff <= mbusy_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in; m_ff <= m_in; r_ff <= r_in; c_ff <= c_in; ga_ff <= ga_in;
      gb_ff <= gb_in; pg_ff <= pg_in; cg_ff <= cg_in; mg_ff <= mg_in; r0_ff <= r0_in;
      r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in; t_ff <= t_in; fhit_ff <= fhit_in;
      ohit_ff <= ohit_in; dq_ff <= dq_in; dd_ff <= dd_in; rem_ff <= rem_in;
      dcnt_ff <= dcnt_in; ma_ff <= ma_in; mb_ff <= mb_in; mn_ff <= mn_in;
      acc_ff <= acc_in; mplain_ff <= mplain_in;
   end

   always_comb begin
      status.unit_busy = dbusy_ff | mbusy_ff;
      status.gcd_zero  = (gb_ff == '0);
      status.r1_zero   = (r1_ff == '0);
      status.fail_hit  = fhit_ff;
      status.ovf_hit   = ohit_ff;
      status.pg_gt1    = (pg_ff > ONE);
      status.skip      = fail_ff | ovf_ff;
      status.at_start  = start_ff;
   end

   assign sol_out  = sol_ff;
   assign mod_out  = mod_ff;
   assign fail_out = fail_ff;
   assign ovf_out  = ovf_ff;
   assign last_out = last_ff;
endmodule

/* src/ecrt_ctrl.sv */
// ecrt_ctrl: sequencer for one congruence merge; issues datapath commands
// and runs the handshakes; depends on ecrt_pkg
module ecrt_ctrl import ecrt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd,
   output logic       close_sys
);
   state_type state_ff, state_in;
   logic      out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; out_ff <= 1'b0;
      end else begin
         state_ff <= state_in; out_ff <= out_in;
      end
   end

   always_comb begin
      state_in = state_ff; out_in = out_ff; cmd.op = OP_NONE; close_sys = 1'b0;
      req_ready = (state_ff == ST_IDLE);
      if (out_ff && rsp_ready) out_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            cmd.op = OP_LOAD; state_in = ST_MODM;
         end
         ST_MODM: begin cmd.op = OP_FIXM; state_in = ST_RMOD; end
         ST_RMOD: if (!status.unit_busy) begin
            cmd.op = OP_SET_RM;
            state_in = (status.at_start || status.skip) ? ST_OUT : ST_AMOD;
         end
         ST_AMOD: begin cmd.op = OP_DIV_AM; state_in = ST_C; end
         ST_C: if (!status.unit_busy) begin cmd.op = OP_SET_AM; state_in = ST_GCD; end
         ST_GCD: begin cmd.op = OP_SETC; state_in = ST_GCDW; end
         ST_GCDW: if (status.gcd_zero) state_in = ST_PG;
                  else begin cmd.op = OP_DIV_GCD; state_in = ST_PGW; end
         ST_PGW: if (!status.unit_busy) begin cmd.op = OP_GCD_STEP; state_in = ST_GCDW; end
         ST_PG: begin cmd.op = OP_DIV_PG; state_in = ST_CG; end
         ST_CG: if (!status.unit_busy) begin cmd.op = OP_SET_PG; state_in = ST_CGW; end
         ST_CGW: if (!status.unit_busy) begin cmd.op = OP_SET_CG; state_in = ST_OVF; end
         ST_OVF: if (!status.unit_busy) begin cmd.op = OP_SET_OVF; state_in = ST_OVFW; end
         ST_OVFW: if (status.fail_hit || status.ovf_hit) state_in = ST_MGW;
                  else state_in = ST_MG;
         ST_MG: if (!status.unit_busy) begin cmd.op = OP_SET_MG; state_in = ST_MGP; end
         ST_MGP: if (!status.unit_busy) begin cmd.op = OP_SET_MGP; state_in = ST_MGPW; end
         ST_MGPW: if (!status.unit_busy) begin
            cmd.op = OP_SET_CGP;
            state_in = status.pg_gt1 ? ST_INV : ST_TMULW;
         end
         ST_INV: if (status.r1_zero) state_in = ST_TMUL;
                 else begin cmd.op = OP_DIV_INV; state_in = ST_INVW; end
         ST_INVW: if (!status.unit_busy) begin cmd.op = OP_MUL_INV; state_in = ST_INVM; end
         ST_INVM: state_in = ST_INVMW;
         ST_INVMW: if (!status.unit_busy) begin cmd.op = OP_INV_STEP; state_in = ST_INV; end
         ST_TMUL: begin cmd.op = OP_MUL_T; state_in = ST_CGPW; end
         ST_CGPW: state_in = ST_TMULW;
         ST_TMULW: if (!status.unit_busy) begin cmd.op = OP_MUL_PROD; state_in = ST_PROD; end
         ST_PROD: state_in = ST_PRODW;
         ST_PRODW: if (!status.unit_busy) begin cmd.op = OP_MUL_LCM; state_in = ST_LCMW; end
         ST_LCMW: if (!status.unit_busy) begin cmd.op = OP_COMMIT; state_in = ST_OUT; end
         ST_MGW: if (!status.unit_busy) state_in = ST_OUT;
         ST_OUT: if (!out_ff || rsp_ready) begin
            cmd.op = OP_CLOSE; close_sys = 1'b1; out_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = out_ff;
endmodule

/* src/extended_crt_combiner_top.sv */
// extended_crt_combiner_top: top level of the crt combiner, controller plus
// datapath and the output register; depends on ecrt_pkg, ecrt_ctrl, ecrt_datapath
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_ready  | modulus, residue, last
//  rsp     | out       | rsp_valid/rsp_ready  | solution, combined_modulus, flags
//
// one word at a time: a merge chains about eight divisions, one more per gcd step,
// a division and a multiply per inverse step and two or three multiplies at the end
// each division forms its quotient one bit a cycle, each multiply consumes one bit
// of its multiplier a cycle and stops once the multiplier bits left are zero
// first word of a system, or a word after a flag, needs only the r mod m division
// reset is synchronous and restores the empty system (solution 0, modulus 1)
// the result sits in an output register; a stalled rsp only holds the next word
module extended_crt_combiner_top import ecrt_pkg::*; #(
   parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [61:0]            req_modulus,
   input  logic [61:0]            req_residue,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [61:0]            rsp_solution,
   output logic [61:0]            rsp_combined_modulus,
   output logic                   rsp_no_solution,
   output logic                   rsp_overflow,
   output logic                   rsp_done_res
);
   cmd_type    cmd;
   status_type status;
   logic       close_sys;
   logic [VALUE_WIDTH-1:0] sol, modv;
   logic fail, ovf, lst;

   // output word register, loaded as the merge completes
   logic [61:0] osol_ff, omod_ff;
   logic        ofail_ff, oovf_ff, olast_ff;

   ecrt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd, .close_sys
   );

   ecrt_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock, .reset, .cmd,
      .m_in_val(req_modulus[VALUE_WIDTH-1:0]),
      .r_in_val(req_residue[VALUE_WIDTH-1:0]),
      .last_in_val(req_last),
      .status, .sol_out(sol), .mod_out(modv), .fail_out(fail), .ovf_out(ovf),
      .last_out(lst)
   );

   always_ff @(posedge clock) begin
      if (close_sys) begin
         osol_ff <= 62'(sol); omod_ff <= 62'(modv);
         ofail_ff <= fail; oovf_ff <= ovf; olast_ff <= lst;
      end
   end

   assign rsp_solution         = osol_ff;
   assign rsp_combined_modulus = omod_ff;
   assign rsp_no_solution      = ofail_ff;
   assign rsp_overflow         = oovf_ff;
   assign rsp_done_res         = olast_ff;
endmodule

/* tb/crt_merge_checker.sv */
// crt_merge_checker: watches the req and rsp channels of the crt combiner, predicts
// each result word and compares it field by field; depends on nothing but its ports
`timescale 1ns / 1ps

module crt_merge_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [61:0] req_modulus,
   input  logic [61:0] req_residue,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [61:0] rsp_solution,
   input  logic [61:0] rsp_combined_modulus,
   input  logic        rsp_no_solution,
   input  logic        rsp_overflow,
   input  logic        rsp_done_res,
   output int          errors,
   output int          pending
);
   localparam longint unsigned VALUE_MASK = (64'd1 << 62) - 64'd1;

   typedef struct packed {
      logic [61:0] solution;
      logic [61:0] lcm;
      logic        no_sol;
      logic        ovf;
      logic        closes;
   } merge_word_type;

   merge_word_type   merged_q[$];
   longint unsigned  sys_solution;
   longint unsigned  sys_lcm;
   bit               sys_fail;
   bit               sys_ovf;
   bit               sys_fresh;

   function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                              longint unsigned n);
      longint unsigned acc;
      acc = 0;
      while (b != 0) begin
         if (b[0]) acc = (acc + a) % n;
         a = (a << 1) % n;
         b = b >> 1;
      end
      return acc;
   endfunction

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic longint unsigned inverse_of(longint unsigned a, longint unsigned n);
      longint unsigned r0, r1, r2, t0, t1, t2, q;
      r0 = n;
      r1 = a % n;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         q  = r0 / r1;
         r2 = r0 - q * r1;
         t2 = (t0 + n - mulmod(q % n, t1, n)) % n;
         r0 = r1;
         r1 = r2;
         t0 = t1;
         t1 = t2;
      end
      return t0;
   endfunction

   function automatic merge_word_type merge_congruence(longint unsigned m_in,
                                                       longint unsigned r_in, bit closes);
      longint unsigned m, r, c, g, pg, t;
      merge_word_type w;
      m = m_in & VALUE_MASK;
      r = r_in & VALUE_MASK;
      if (m == 0) m = 1;
      r = r % m;
      if (sys_fresh) begin
         sys_lcm      = m;
         sys_solution = r;
         sys_fail     = 0;
         sys_ovf      = 0;
         sys_fresh    = 0;
      end else if (!sys_fail && !sys_ovf) begin
         c  = (r + m - (sys_solution % m)) % m;
         g  = gcd_of(sys_lcm, m);
         pg = m / g;
         if (c % g != 0) sys_fail = 1;
         else if (sys_lcm > VALUE_MASK / pg) sys_ovf = 1;
         else begin
            t = 0;
            if (pg > 1)
               t = mulmod(inverse_of((sys_lcm / g) % pg, pg), (c / g) % pg, pg);
            sys_solution = sys_solution + sys_lcm * t;
            sys_lcm      = sys_lcm * pg;
         end
      end
      if (closes) sys_fresh = 1;
      w.solution = sys_solution[61:0];
      w.lcm      = sys_lcm[61:0];
      w.no_sol   = sys_fail;
      w.ovf      = sys_ovf;
      w.closes   = closes;
      return w;
   endfunction

   always @(posedge clock) begin
      merge_word_type want;
      if (reset) begin
         merged_q.delete();
         errors       = 0;
         sys_solution = 0;
         sys_lcm      = 1;
         sys_fail     = 0;
         sys_ovf      = 0;
         sys_fresh    = 1;
      end else begin
         if (req_valid && req_ready)
            merged_q.push_back(merge_congruence({2'b00, req_modulus}, {2'b00, req_residue},
                                                req_last));
         if (rsp_valid && rsp_ready) begin
            if (merged_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result word sol=%h lcm=%h", $realtime,
                           rsp_solution, rsp_combined_modulus);
            end else begin
               want = merged_q.pop_front();
               if (rsp_solution !== want.solution || rsp_combined_modulus !== want.lcm ||
                   rsp_no_solution !== want.no_sol || rsp_overflow !== want.ovf ||
                   rsp_done_res !== want.closes) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch exp %h %h %b%b%b got %h %h %b%b%b",
                              $realtime, want.solution, want.lcm, want.no_sol, want.ovf,
                              want.closes, rsp_solution, rsp_combined_modulus,
                              rsp_no_solution, rsp_overflow, rsp_done_res);
               end
            end
         end
      end
      pending = merged_q.size();
   end
endmodule

/* tb/tb_extended_crt_combiner_top.sv */
// tb_extended_crt_combiner_top: stimulus and verdict for the crt combiner;
// depends on extended_crt_combiner_top, ecrt_pkg and crt_merge_checker
`timescale 1ns / 1ps

module tb_extended_crt_combiner_top;
   localparam longint unsigned FULL_MASK = (64'd1 << 62) - 64'd1;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [61:0] req_modulus = 0;
   logic [61:0] req_residue = 0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [61:0] rsp_solution;
   logic [61:0] rsp_combined_modulus;
   logic        rsp_no_solution;
   logic        rsp_overflow;
   logic        rsp_done_res;
   int          errors;
   int          pending;
   int          gap_pct = 0;     // chance in a hundred that the sender idles a cycle
   int          stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle

   always #4 clock = ~clock;

   extended_crt_combiner_top uut (.*);

   crt_merge_checker chk (.*);

   // receiver: random back-pressure, drawn fresh each cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // hand one congruence word over, with random idle cycles first
   task automatic send_congruence(longint unsigned m, longint unsigned r, bit closes);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid   <= 1;
      req_modulus <= m[61:0];
      req_residue <= r[61:0];
      req_last    <= closes;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic longint unsigned rand_wide();
      return {$urandom, $urandom} & FULL_MASK;
   endfunction

   // moduli mostly small so the euclid loops stay short, some up to full width, a few zero
   function automatic longint unsigned rand_modulus();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return $urandom_range(4095, 1);
      else if (pick < 90) return $urandom_range(1048575, 1);
      else if (pick < 97) return rand_wide() >> $urandom_range(40, 0);
      else return 0;
   endfunction

   // a system of a few congruences, most of them consistent with a hidden x
   task automatic random_system();
      longint unsigned x, m, r;
      int n;
      n = $urandom_range(6, 1);
      x = ($urandom_range(3) == 0) ? rand_wide() : longint'($urandom);
      for (int i = 0; i < n; i++) begin
         m = rand_modulus();
         if ($urandom_range(99) < 80) r = (m == 0) ? rand_wide() : x % m;
         else if ($urandom_range(1)) r = rand_wide();
         else r = $urandom_range(4095);
         // a residue beyond the modulus must still reduce correctly
         if ($urandom_range(9) == 0 && m != 0 && m < FULL_MASK / 4) r = r + m * $urandom_range(3);
         send_congruence(m, r, i == n - 1);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: single word systems at the field extremes
      send_congruence(1, 0, 1);
      send_congruence(FULL_MASK, FULL_MASK, 1);         // residue equal to modulus
      send_congruence(0, FULL_MASK, 1);                 // zero modulus acts as one
      send_congruence(7, 100, 1);                       // residue above modulus
      // coprime merge
      send_congruence(3, 2, 0);
      send_congruence(5, 3, 0);
      send_congruence(7, 2, 1);
      // shared factor, consistent
      send_congruence(6, 4, 0);
      send_congruence(4, 2, 0);
      send_congruence(0, 12345, 1);                     // zero modulus inside a system
      // inconsistent, then further words ignored until closed
      send_congruence(6, 1, 0);
      send_congruence(4, 2, 0);
      send_congruence(5, 3, 1);
      // lcm too wide, stays flagged until the system closes
      send_congruence(FULL_MASK >> 1, 5, 0);
      send_congruence(FULL_MASK - 2, 9, 0);
      send_congruence(3, 1, 1);
      // same modulus twice, repeated residue and then a clash
      send_congruence(FULL_MASK, 77, 0);
      send_congruence(FULL_MASK, 77, 0);
      send_congruence(FULL_MASK, 78, 1);
      // large coprime pair whose lcm just fits
      send_congruence(64'd2147483647, 64'd1000, 0);
      send_congruence(64'd2147483629, 64'd2000, 1);

      // random systems in three idling phases
      gap_pct = 16; stall_pct = 69;
      for (int k = 0; k < 130; k++) random_system();
      gap_pct = 69; stall_pct = 16;
      for (int k = 0; k < 130; k++) random_system();
      gap_pct = 0; stall_pct = 0;
      for (int k = 0; k < 130; k++) random_system();
      req_valid <= 0;

      // drain, then let the block settle for a while
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("tb_extended_crt_combiner_top: clean");
      else
         $display("tb_extended_crt_combiner_top: errors");
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #(64'd900_000_000);
      $display("tb_extended_crt_combiner_top: errors");
      $finish;
   end
endmodule

/* sim.f */
src/ecrt_pkg.sv
src/ecrt_datapath.sv
src/ecrt_ctrl.sv
src/extended_crt_combiner_top.sv
tb/crt_merge_checker.sv
tb/tb_extended_crt_combiner_top.sv
